// ===== design/html_entity_escaper_assert.svh =====
// ----------------------------------------------------------------------------
// html entity escaper assertion macros
// shared property wrappers, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_ESCAPER_ASSERT_SVH
`define HTML_ENTITY_ESCAPER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define HEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== design/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// hee_pkg
// types, entity table and byte classification for the html entity escaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hee_pkg;

  // what a kept byte turns into on the output
  typedef enum logic [3:0] {
    KIND_QUOT  = 4'd0,
    KIND_APOS  = 4'd1,
    KIND_BSL   = 4'd2,
    KIND_LBR   = 4'd3,
    KIND_RBR   = 4'd4,
    KIND_BAR   = 4'd5,
    KIND_PCT   = 4'd6,
    KIND_COLON = 4'd7,
    KIND_LT    = 4'd8,
    KIND_GT    = 4'd9,
    KIND_PLAIN = 4'd10
  } hee_kind_t;

  typedef struct packed {
    hee_kind_t   kind;
    logic [7:0]  data;
  } hee_entry_t;

  localparam int unsigned ENT_MAX = 6;
  localparam int unsigned POS_W   = 3;

  // entity strings, left aligned in ENT_MAX bytes
  localparam logic [8*ENT_MAX-1:0] ENT_QUOT  = "&quot;";
  localparam logic [8*ENT_MAX-1:0] ENT_APOS  = {"&#39;", 8'h00};
  localparam logic [8*ENT_MAX-1:0] ENT_BSL   = {"&#92;", 8'h00};
  localparam logic [8*ENT_MAX-1:0] ENT_LBR   = "&#123;";
  localparam logic [8*ENT_MAX-1:0] ENT_RBR   = "&#125;";
  localparam logic [8*ENT_MAX-1:0] ENT_BAR   = "&#124;";
  localparam logic [8*ENT_MAX-1:0] ENT_PCT   = {"&#37;", 8'h00};
  localparam logic [8*ENT_MAX-1:0] ENT_COLON = {"&#58;", 8'h00};
  localparam logic [8*ENT_MAX-1:0] ENT_LT    = {"&lt;", 16'h0000};
  localparam logic [8*ENT_MAX-1:0] ENT_GT    = {"&gt;", 16'h0000};

  function automatic logic is_white(input logic [7:0] b);
    is_white = b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic hee_kind_t classify(input logic [7:0] b);
    case (b)
      8'h22:   classify = KIND_QUOT;
      8'h27:   classify = KIND_APOS;
      8'h5C:   classify = KIND_BSL;
      8'h7B:   classify = KIND_LBR;
      8'h7D:   classify = KIND_RBR;
      8'h7C:   classify = KIND_BAR;
      8'h25:   classify = KIND_PCT;
      8'h3A:   classify = KIND_COLON;
      8'h3C:   classify = KIND_LT;
      8'h3E:   classify = KIND_GT;
      default: classify = KIND_PLAIN;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] ent_len(input hee_kind_t k);
    case (k)
      KIND_QUOT, KIND_LBR, KIND_RBR, KIND_BAR:   ent_len = 3'd6;
      KIND_APOS, KIND_BSL, KIND_PCT, KIND_COLON: ent_len = 3'd5;
      KIND_LT, KIND_GT:                          ent_len = 3'd4;
      default:                                   ent_len = 3'd1;
    endcase
  endfunction

  function automatic logic [8*ENT_MAX-1:0] ent_text(input hee_kind_t k);
    case (k)
      KIND_QUOT:  ent_text = ENT_QUOT;
      KIND_APOS:  ent_text = ENT_APOS;
      KIND_BSL:   ent_text = ENT_BSL;
      KIND_LBR:   ent_text = ENT_LBR;
      KIND_RBR:   ent_text = ENT_RBR;
      KIND_BAR:   ent_text = ENT_BAR;
      KIND_PCT:   ent_text = ENT_PCT;
      KIND_COLON: ent_text = ENT_COLON;
      KIND_LT:    ent_text = ENT_LT;
      KIND_GT:    ent_text = ENT_GT;
      default:    ent_text = '0;
    endcase
  endfunction

  // byte number pos of the expansion of entry e
  function automatic logic [7:0] ent_char(input hee_entry_t e, input logic [POS_W-1:0] pos);
    logic [8*ENT_MAX-1:0] txt;
    logic [POS_W-1:0]     sel;
    txt = ent_text(e.kind);
    sel = POS_W'(ENT_MAX - 1) - pos;
    if (e.kind == KIND_PLAIN) begin
      ent_char = e.data;
    end else begin
      ent_char = txt[{sel, 3'b000} +: 8];
    end
  endfunction

endpackage

// ===== design/hee_ifs.sv =====
// ----------------------------------------------------------------------------
// hee channel interfaces
// valid/ready channels for input text bytes and escaped output bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       starts_text;

  modport source (output valid, output text_byte, output starts_text, input ready);
  modport sink (input valid, input text_byte, input starts_text, output ready);
endinterface

interface hee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== design/html_entity_escaper.sv =====
// ----------------------------------------------------------------------------
// html_entity_escaper
// streaming html entity escaper with whitespace collapsing
// ----------------------------------------------------------------------------
// Takes text one byte per input beat and emits the escaped text one byte per
// output beat. Whitespace (space, tab, newline, vertical tab, form feed,
// carriage return) at the start of a text or after a kept whitespace byte is
// dropped; starts_text marks the first byte of a new text. The ten special
// characters " ' \ { } | % : < > become their entity strings (4 to 6 beats),
// every other byte passes as one beat, and last_of_run flags the final beat
// of each input byte. Rate: the input side takes one byte per cycle as long
// as the entry queue has room; the output side gives one beat per cycle
// while the queue holds an entry and the sink is ready, so a plain byte
// gives one beat and a special character as many beats as its entity has
// bytes. A dropped byte is taken on the input and gives no output. From
// input beat to first output beat a byte passes the classify register of
// the front, the entry queue and the output register of the back. The queue
// (QUEUE_DEPTH entries, 2 to 32) lets the front keep taking bytes while the
// back expands an entity.
`timescale 1ns / 1ps

module html_entity_escaper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  hee_in_if.sink   text_in,
  hee_out_if.source text_out
);
  import hee_pkg::*;

  // front to queue
  logic       push;
  hee_entry_t push_entry;
  logic       full;

  // queue to back
  logic       pop;
  hee_entry_t head;
  logic       empty;

  // classify and drop redundant whitespace
  hee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // decouples intake from entity expansion
  hee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  // expand entries into output beats
  hee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .text_out (text_out)
  );

endmodule

// ===== design/hee_front.sv =====
// ----------------------------------------------------------------------------
// hee_front
// accepts input beats, drops redundant whitespace, classifies kept bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hee_front (
  input  logic              clk,
  input  logic              rst,
  hee_in_if.sink            text_in,
  output logic              push,
  output hee_pkg::hee_entry_t push_entry,
  input  logic              full
);
  import hee_pkg::*;

  logic       slot_valid;
  hee_entry_t slot;
  logic       prev_space;

  logic accept;
  logic space_mem;
  logic white;
  logic drop;

  assign push           = slot_valid && !full;
  assign push_entry     = slot;
  assign text_in.ready  = !slot_valid || !full;
  assign accept         = text_in.valid && text_in.ready;

  // a new text behaves as if a space was just kept
  assign space_mem = text_in.starts_text || prev_space;
  assign white     = is_white(text_in.text_byte);
  assign drop      = space_mem && white;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      prev_space <= 1'b1;
    end else begin
      slot_valid <= (accept && !drop) || (slot_valid && !push);
      if (accept) begin
        // a dropped blank keeps the space memory set, also when it opens a text
        prev_space <= drop ? 1'b1 : white;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      slot.kind <= classify(text_in.text_byte);
      slot.data <= text_in.text_byte;
    end
  end

endmodule

// ===== design/hee_fifo.sv =====
// ----------------------------------------------------------------------------
// hee_fifo
// short register queue of classified entries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "html_entity_escaper_assert.svh"

module hee_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hee_pkg::hee_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output hee_pkg::hee_entry_t head,
  output logic                empty
);
  import hee_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hee_entry_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  `HEE_ASSERT(a_fifo_full_ptrs, full |-> wr_ptr == rd_ptr, "fifo full with pointers apart")
  `HEE_ASSERT(a_fifo_count_bound, count <= CNT_W'(DEPTH), "fifo count beyond depth")

endmodule

// ===== design/hee_back.sv =====
// ----------------------------------------------------------------------------
// hee_back
// expands queued entries into output beats through a registered output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "html_entity_escaper_assert.svh"

module hee_back (
  input  logic                clk,
  input  logic                rst,
  input  hee_pkg::hee_entry_t head,
  input  logic                empty,
  output logic                pop,
  hee_out_if.source           text_out
);
  import hee_pkg::*;

  logic             o_valid;
  logic [7:0]       o_byte;
  logic             o_last;
  logic [POS_W-1:0] pos;

  logic             load;
  logic             last;
  logic [POS_W-1:0] len;

  assign len  = ent_len(head.kind);
  assign last = pos == len - 1'b1;
  assign load = !empty && (!o_valid || text_out.ready);
  assign pop  = load && last;

  assign text_out.valid       = o_valid;
  assign text_out.out_byte    = o_byte;
  assign text_out.last_of_run = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      pos     <= '0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        pos     <= last ? '0 : pos + 1'b1;
      end else if (text_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_byte <= ent_char(head, pos);
      o_last <= last;
    end
  end

  `HEE_ASSERT(a_pos_in_range, !empty |-> pos < len, "expansion position past entity end")
  `HEE_ASSERT_NEXT(a_pos_restart, pop, pos == '0, "position not restarted after last beat")
  `HEE_ASSERT_NEXT(a_last_marks_pop, load && last, o_valid && o_last, "last beat not marked")

endmodule
